// ===== rtl/arrp_pkg.sv =====
// arrp_pkg: shared types and constants of the rangefinder reply parser
// no dependencies; imported by the front, queue and back modules
package arrp_pkg;

	localparam logic [7:0] CH_M = 8'h6d;
	localparam logic [7:0] CH_O = 8'h6f;
	localparam logic [7:0] CH_K = 8'h6b;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic [15:0] DIST_RESET = 16'd2000;
	localparam int          NUM_DIGITS = 4;

	localparam logic [15:0] WEIGHT_10   = 16'd10;
	localparam logic [15:0] WEIGHT_100  = 16'd100;
	localparam logic [15:0] WEIGHT_1000 = 16'd1000;

	typedef enum logic [1:0] {
		CMD_PLAIN,
		CMD_ACK,
		CMD_PARSE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic [NUM_DIGITS-1:0]       dig_vld;
		logic [NUM_DIGITS-1:0][3:0]  dig;
	} cmd_t;

endpackage

// ===== rtl/arrp_ifs.sv =====
// arrp_ifs: valid/ready channel interfaces of the reply parser
// no dependencies; used by the front, back and top level
interface arrp_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source(output valid, output opcode, output rx_byte, input ready);
	modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

interface arrp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance_mm;
	logic        new_distance;
	logic        ack_seen;

	modport source(output valid, output distance_mm, output new_distance, output ack_seen,
		input ready);
	modport sink(input valid, input distance_mm, input new_distance, input ack_seen,
		output ready);
endinterface

// ===== rtl/ascii_range_reply_parser_top.sv =====
// ascii_range_reply_parser_top: rangefinder reply parser, front, queue, back
// depends on arrp_pkg, arrp_ifs, arrp_front, arrp_queue, arrp_back
//
//   channel  dir  payload                                  handshake
//   req      in   opcode[0], rx_byte[7:0]                  valid/ready
//   rsp      out  distance_mm[15:0], new_distance, ack_seen valid/ready
//
// one word accepted per cycle while the queue is not full; its result passes
// through the queue into the output register; the front updates position and
// pair tracking per word, the back weights the digits from the two-entry queue
// req.ready drops only while the queue is full (rsp stalled)
// reset clears position, ack mode and queue; distance resets to 2000
module ascii_range_reply_parser_top
	import arrp_pkg::*;
#(
	parameter int STORE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	arrp_in_if.sink    req,
	arrp_out_if.source rsp
);

	logic push;
	logic full;
	logic pop;
	logic empty;
	cmd_t push_cmd;
	cmd_t head;

	arrp_front #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	arrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	arrp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/arrp_front.sv =====
// arrp_front: accepts input words, tracks the byte position, ack mode and
// the first "mm" pair of the current pass, and issues one command per word
// depends on arrp_pkg and arrp_in_if
module arrp_front
	import arrp_pkg::*;
#(
	parameter int STORE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	arrp_in_if.sink      req,
	input  logic         full,
	output logic         push,
	output cmd_t         cmd
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int HIST = NUM_DIGITS + 1;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WAIT,
		MODE_SEEN
	} mode_t;

	mode_t                       mode_q;
	logic [PW-1:0]               pos_q;
	logic [HIST-1:0][7:0]        hist_q;
	logic                        found_q;
	logic [NUM_DIGITS-1:0]       sav_vld_q;
	logic [NUM_DIGITS-1:0][3:0]  sav_dig_q;

	logic                        accept;
	logic                        pair_now;
	logic                        parse_now;
	logic                        ack_now;
	logic                        pos_ge2;
	logic                        last_pos;
	logic [NUM_DIGITS-1:0]       cur_vld;
	logic [NUM_DIGITS-1:0][3:0]  cur_dig;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

	assign req.ready = !full;
	assign accept    = req.valid && !full;
	assign push      = accept;

	assign pos_ge2   = pos_q >= PW'(2);
	assign last_pos  = pos_q == PW'(STORE_DEPTH - 1);
	assign pair_now  = (pos_q != '0) && (hist_q[0] == CH_M) && (req.rx_byte == CH_M);
	assign parse_now = pos_ge2 && (mode_q != MODE_WAIT) && pair_now;
	assign ack_now   = pos_ge2 && (mode_q == MODE_WAIT) && (hist_q[0] == CH_O)
		&& (req.rx_byte == CH_K);

	// digits in front of a pair that ends at the current byte
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			cur_vld[k] = (pos_q >= PW'(k + 2)) && is_digit(hist_q[k+1]);
			cur_dig[k] = hist_q[k+1][3:0];
		end
	end

	always_comb begin
		cmd.dig_vld = found_q ? sav_vld_q : cur_vld;
		cmd.dig     = found_q ? sav_dig_q : cur_dig;
		priority if (req.opcode) begin
			cmd.kind = CMD_PLAIN;
		end else if (parse_now) begin
			cmd.kind = CMD_PARSE;
		end else if (ack_now) begin
			cmd.kind = CMD_ACK;
		end else begin
			cmd.kind = CMD_PLAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			pos_q     <= '0;
			hist_q    <= '0;
			found_q   <= 1'b0;
			sav_vld_q <= '0;
			sav_dig_q <= '0;
		end else if (accept) begin
			if (req.opcode) begin
				mode_q <= MODE_WAIT;
			end else begin
				hist_q[0] <= req.rx_byte;
				for (int i = 1; i < HIST; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (ack_now) begin
					mode_q <= MODE_SEEN;
				end
				// a parse or a wrap starts a new pass
				priority if (parse_now || last_pos) begin
					pos_q   <= '0;
					found_q <= 1'b0;
				end else begin
					pos_q <= pos_q + PW'(1);
					if (pair_now && !found_q) begin
						found_q   <= 1'b1;
						sav_vld_q <= cur_vld;
						sav_dig_q <= cur_dig;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/arrp_queue.sv =====
// arrp_queue: two-entry command queue between front and back
// depends on arrp_pkg
module arrp_queue
	import arrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/arrp_back.sv =====
// arrp_back: carries out queued commands, holds the working and reported
// distance and the output register; depends on arrp_pkg and arrp_out_if
module arrp_back
	import arrp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      head,
	output logic      pop,
	arrp_out_if.source rsp
);

	logic [15:0] work_q;
	logic [15:0] rept_q;
	logic        vld_q;
	logic [15:0] dist_q;
	logic        newd_q;
	logic        ack_q;

	logic [15:0] work_nx;

	assign pop = !empty && (!vld_q || rsp.ready);

	// first digit overwrites, the others add with 16-bit wrap
	always_comb begin
		work_nx = head.dig_vld[0] ? {12'd0, head.dig[0]} : work_q;
		if (head.dig_vld[1]) begin
			work_nx = work_nx + {12'd0, head.dig[1]} * WEIGHT_10;
		end
		if (head.dig_vld[2]) begin
			work_nx = work_nx + {12'd0, head.dig[2]} * WEIGHT_100;
		end
		if (head.dig_vld[3]) begin
			work_nx = work_nx + {12'd0, head.dig[3]} * WEIGHT_1000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= DIST_RESET;
			rept_q <= DIST_RESET;
			vld_q  <= 1'b0;
			dist_q <= DIST_RESET;
			newd_q <= 1'b0;
			ack_q  <= 1'b0;
		end else begin
			if (pop) begin
				vld_q <= 1'b1;
				unique case (head.kind)
					CMD_PARSE: begin
						work_q <= work_nx;
						rept_q <= work_nx;
						dist_q <= work_nx;
						newd_q <= 1'b1;
						ack_q  <= 1'b0;
					end
					CMD_ACK: begin
						dist_q <= rept_q;
						newd_q <= 1'b0;
						ack_q  <= 1'b1;
					end
					default: begin
						dist_q <= rept_q;
						newd_q <= 1'b0;
						ack_q  <= 1'b0;
					end
				endcase
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = vld_q;
	assign rsp.distance_mm  = dist_q;
	assign rsp.new_distance = newd_q;
	assign rsp.ack_seen     = ack_q;

endmodule

// ===== tb/ascii_range_reply_parser_top_tb.sv =====
// ascii_range_reply_parser_top_tb: self-checking bench for the rangefinder reply parser
// depends on arrp_pkg, arrp_ifs and ascii_range_reply_parser_top; drives bytes and
// commands, predicts each reply word and compares it with what the parser returns
module ascii_range_reply_parser_top_tb;
	import arrp_pkg::*;

	localparam int STORE_DEPTH    = 16;
	localparam int RANDOM_WORDS   = 1370;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef enum logic [1:0] {
		ACK_IDLE,
		ACK_WAIT,
		ACK_DONE
	} ack_state_t;

	typedef struct packed {
		logic [15:0] distance_mm;
		logic        new_distance;
		logic        ack_seen;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	arrp_in_if  req_if ();
	arrp_out_if rsp_if ();

	ascii_range_reply_parser_top #(
		.STORE_DEPTH(STORE_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted parser state
	logic [7:0]  rx_store [STORE_DEPTH];
	int          wr_pos;
	ack_state_t  ack_state;
	logic [15:0] work_dist;
	logic [15:0] shown_dist;

	reply_t pending_replies [$];
	int     errors = 0;
	int     words_sent = 0;
	bit     tx_idle_on = 1'b1;
	bit     rx_idle_on = 1'b1;
	bit     hold_request = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// mostly characters the parser reacts to, some arbitrary bytes
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CH_0 + 8'($urandom_range(0, 9));
		else if (r < 55)
			return CH_M;
		else if (r < 65)
			return CH_O;
		else if (r < 75)
			return CH_K;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic reply_t predict_reply(input logic op, input logic [7:0] b);
		reply_t      r;
		int          cnt;
		int          hit;
		int          j;
		logic [15:0] d;
		logic [15:0] v;
		r.new_distance = 1'b0;
		r.ack_seen     = 1'b0;
		if (op == OP_CMD) begin
			ack_state = ACK_WAIT;
		end else begin
			if (wr_pos >= STORE_DEPTH)
				wr_pos = 0;
			rx_store[wr_pos] = b;
			cnt = wr_pos + 1;
			wr_pos = cnt;
			if (cnt > 2) begin
				if (ack_state == ACK_WAIT) begin
					if (rx_store[cnt-2] == CH_O && rx_store[cnt-1] == CH_K) begin
						ack_state  = ACK_DONE;
						r.ack_seen = 1'b1;
					end
				end else if (rx_store[cnt-1] == CH_M && rx_store[cnt-2] == CH_M) begin
					// the first pair in the store wins, not the newest one
					hit = -1;
					for (int i = 0; i < cnt && i + 1 < STORE_DEPTH && hit < 0; i++)
						if (rx_store[i] == CH_M && rx_store[i+1] == CH_M)
							hit = i;
					if (hit >= 0) begin
						for (int k = 0; k < NUM_DIGITS; k++) begin
							j = hit - 1 - k;
							if (hit > k && rx_store[j] >= CH_0 && rx_store[j] <= CH_9) begin
								d = 16'(rx_store[j] - CH_0);
								case (k)
									0: v = d;
									1: v = d * WEIGHT_10;
									2: v = d * WEIGHT_100;
									default: v = d * WEIGHT_1000;
								endcase
								if (k == 0)
									work_dist = v;
								else
									work_dist = work_dist + v;
							end
						end
					end
					shown_dist     = work_dist;
					wr_pos         = 0;
					r.new_distance = 1'b1;
				end
			end
			if (wr_pos >= STORE_DEPTH)
				wr_pos = 0;
		end
		r.distance_mm = shown_dist;
		return r;
	endfunction

	// called and returns just after a falling edge; valid stays up for the next word
	task automatic send_word(input logic op, input logic [7:0] b);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid   = 1'b1;
		req_if.opcode  = op;
		req_if.rx_byte = b;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pending_replies.push_back(predict_reply(op, b));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(OP_BYTE, s[i]);
	endtask

	// receiver side: random stalls, plus one long hold on request
	initial begin
		int gap_left;
		int hold_left;
		rsp_if.ready = 1'b0;
		gap_left  = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				rsp_if.ready = 1'b0;
			end else begin
				rsp_if.ready = 1'b1;
				if (rx_idle_on)
					gap_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with none expected: distance_mm=%0d new_distance=%0b ack_seen=%0b",
					$time, rsp_if.distance_mm, rsp_if.new_distance, rsp_if.ack_seen);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_if.distance_mm !== want.distance_mm) begin
					$display("%0t: distance_mm expected %0d actual %0d",
						$time, want.distance_mm, rsp_if.distance_mm);
					errors++;
				end
				if (rsp_if.new_distance !== want.new_distance) begin
					$display("%0t: new_distance expected %0b actual %0b",
						$time, want.new_distance, rsp_if.new_distance);
					errors++;
				end
				if (rsp_if.ack_seen !== want.ack_seen) begin
					$display("%0t: ack_seen expected %0b actual %0b",
						$time, want.ack_seen, rsp_if.ack_seen);
					errors++;
				end
			end
		end
	end

	// ends the run when neither channel moves for too long
	initial begin
		int stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// "mm" at the first two entries is too short; the third 'm' parses with no digits
	task automatic test_short_fill();
		send_text("mmm");
	endtask

	task automatic test_four_digits();
		send_text("1234mm");
	endtask

	// a non-digit right before the pair leaves the old value to be added to
	task automatic test_old_value_add();
		send_text("98xmm");
	endtask

	task automatic test_ack_handshake();
		send_word(OP_CMD, 8'hff);
		send_word(OP_BYTE, 8'h00);
		send_text("ok");
	endtask

	// while awaiting the ack a pair does not parse; after it the earlier pair is used
	task automatic test_ack_blocks_parse();
		send_word(OP_CMD, 8'h00);
		send_text("5mmok");
		send_word(OP_BYTE, 8'hff);
		send_text("mm");
	endtask

	task automatic test_receiver_backpressure();
		tx_idle_on   = 1'b0;
		rx_idle_on   = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++)
			send_word(OP_BYTE, pick_char());
		send_text("4321mm");
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int first;
		int n;
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				tx_idle_on = !tx_idle_on;
			if ($urandom_range(0, 9) == 0)
				rx_idle_on = !rx_idle_on;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					// distance reply, sometimes with junk or too many digits
					n = $urandom_range(0, 2);
					repeat (n) send_word(OP_BYTE, pick_char());
					n = $urandom_range(0, 5);
					repeat (n) begin
						if ($urandom_range(0, 4) == 0)
							send_word(OP_BYTE, 8'($urandom_range(0, 255)));
						else
							send_word(OP_BYTE, CH_0 + 8'($urandom_range(0, 9)));
					end
					send_text("mm");
					if ($urandom_range(0, 1) == 0) begin
						send_word(OP_BYTE, CH_CR);
						send_word(OP_BYTE, CH_LF);
					end
				end
				8, 9, 10, 11: begin
					// command then its acknowledge, with noise or a blocked reply
					send_word(OP_CMD, 8'($urandom_range(0, 255)));
					n = $urandom_range(0, 3);
					repeat (n) send_word(OP_BYTE, pick_char());
					if ($urandom_range(0, 2) == 0)
						send_text("12mm");
					send_text("ok");
				end
				12, 13, 14: begin
					// broken sequences
					if ($urandom_range(0, 1) == 0) begin
						send_word(OP_BYTE, CH_0 + 8'($urandom_range(0, 9)));
						send_word(OP_BYTE, CH_M);
						send_word(OP_BYTE, 8'($urandom_range(0, 255)));
					end else begin
						send_word(OP_BYTE, CH_O);
						send_word(OP_BYTE, 8'($urandom_range(0, 255)));
					end
				end
				15, 16, 17, 18: begin
					n = $urandom_range(1, 20);
					repeat (n) begin
						if ($urandom_range(0, 15) == 0)
							send_word(OP_CMD, 8'($urandom_range(0, 255)));
						else
							send_word(OP_BYTE, pick_char());
					end
				end
				default: begin
					// long run without 'm' so the write position wraps
					n = $urandom_range(16, 24);
					repeat (n) send_word(OP_BYTE, CH_0 + 8'($urandom_range(0, 9)));
				end
			endcase
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.opcode  = OP_BYTE;
		req_if.rx_byte = 8'h00;
		for (int i = 0; i < STORE_DEPTH; i++)
			rx_store[i] = 8'h00;
		wr_pos     = 0;
		ack_state  = ACK_IDLE;
		work_dist  = DIST_RESET;
		shown_dist = DIST_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_fill();
		test_four_digits();
		test_old_value_add();
		test_ack_handshake();
		test_ack_blocks_parse();
		test_receiver_backpressure();
		test_random_traffic();

		req_if.valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
